// ===== rtl/core/chash_pkg.sv =====
// ---------------------------------------------------------------------------
// chash_pkg
// Shared constants, types and the remainder step for the name hash block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package chash_pkg;

  localparam int HASH_BYTES_DEF = 8;
  localparam int ACC_W          = 32;

  // Finalization moduli and the widths of their remainders.
  localparam int MOD_A   = 20117;
  localparam int MOD_B   = 1217;
  localparam int MOD_C   = 157;
  localparam int REM_A_W = 15;
  localparam int REM_B_W = 11;
  localparam int REM_C_W = 8;
  localparam int REM_W   = 16;

  // Remainders are built four accumulator bits per cycle, MSB first.
  localparam int NIB_W     = 4;
  localparam int NIB_STEPS = ACC_W / NIB_W;
  localparam int STEP_W    = $clog2(NIB_STEPS);

  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    FIN_IDLE,
    FIN_CALC,
    FIN_EMIT
  } fin_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic emit;
  } fin_status_t;

  // Four restoring compare-subtract steps of a remainder by a constant modulus.
  function automatic logic [REM_W-1:0] rem_nibble(input logic [REM_W-1:0] r_in,
                                                  input logic [NIB_W-1:0] nib,
                                                  input logic [REM_W-1:0] m);
    logic [REM_W-1:0] r;
    r = r_in;
    for (int j = NIB_W - 1; j >= 0; j--) begin
      r = {r[REM_W-2:0], nib[j]};
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/class_name_id_hash.sv =====
// ---------------------------------------------------------------------------
// class_name_id_hash
// Streaming name hash: bytes in, HASH_BYTES finalized hash bytes out per name.
// ---------------------------------------------------------------------------
//  Channel | Dir | tdata          | tuser              | tlast
//  s_*     | in  | [7:0] name byte | [0] byte valid     | end of name
//  m_*     | out | [7:0] hash byte | [2:0] byte index   | last hash byte
//
// The front absorbs one word per cycle, while s_tready is high, into the
// HASH_BYTES lane accumulators; the shift amounts of each lane are kept as
// registers that step once per byte. An end-of-name word copies the
// accumulators into a two-entry queue and clears the front in the same
// cycle, so the next name may follow at once. The back loads a name, then
// runs per hash byte eight four-bit remainder steps over the three moduli
// and an emit step, which waits while the output holds an untaken byte;
// s_tready drops only while both queue slots hold unfinished names.
// Reset is synchronous and clears the accumulators, queue and back control.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module class_name_id_hash
  import chash_pkg::*;
#(
  parameter int HASH_BYTES = HASH_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] name_byte
  input  logic       s_tuser,   // [0] byte_valid
  input  logic       s_tlast,   // end_of_name
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] hash_byte
  output logic [2:0] m_tuser,   // [2:0] byte_index
  output logic       m_tlast    // last_byte
);

  logic                        s_accept;
  logic                        push;
  logic                        pop;
  logic [HASH_BYTES*ACC_W-1:0] snapshot;
  logic [HASH_BYTES*ACC_W-1:0] head;
  q_status_t                   q_stat;
  fin_status_t                 fin_stat;

  // The front never waits on anything but queue space.
  assign s_tready = ~q_stat.full;
  assign s_accept = s_tvalid & s_tready;

  chash_front #(
    .HASH_BYTES(HASH_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_accept),
    .name_byte  (s_tdata),
    .byte_valid (s_tuser),
    .end_of_name(s_tlast),
    .push       (push),
    .snapshot   (snapshot)
  );

  chash_queue #(
    .WIDTH(HASH_BYTES * ACC_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(snapshot),
    .pop    (pop),
    .head   (head),
    .status (q_stat)
  );

  chash_back #(
    .HASH_BYTES(HASH_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_status(q_stat),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .status  (fin_stat)
  );

`ifndef SYNTH
  // The last byte of a run always carries the final lane index.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == 3'(HASH_BYTES - 1))
    else $error("last hash byte carries a wrong index");

  // The back only works while its name is still held in the queue.
  a_busy_has_entry: assert property (@(posedge clk) disable iff (rst)
    fin_stat.busy |-> !q_stat.empty)
    else $error("finalizer busy with an empty queue");

  // A finished name is never offered to a full queue.
  a_no_lost_name: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("name pushed into a full queue");

  // A byte is emitted only into a free or draining output register.
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    fin_stat.emit |-> !m_tvalid || m_tready)
    else $error("hash byte overwrote a waiting output");
`endif

endmodule

// ===== rtl/core/chash_front.sv =====
// ---------------------------------------------------------------------------
// chash_front
// Absorbs name bytes into the lane accumulators and hands off finished names.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chash_front
  import chash_pkg::*;
#(
  parameter int HASH_BYTES = HASH_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  name_byte,
  input  logic                        byte_valid,
  input  logic                        end_of_name,
  output logic                        push,
  output logic [HASH_BYTES*ACC_W-1:0] snapshot
);

  assign push = accept & end_of_name;

  for (genvar g = 0; g < HASH_BYTES; g++) begin : g_lane
    // Each lane keeps its two shift amounts directly; one more byte position
    // advances them by a fixed step per lane.
    localparam logic [3:0] D1     = 4'((5 * (g + 1)) % 13);
    localparam logic [3:0] S1_RST = 4'((2 * (g + 1) * 5 + 4) % 13);
    localparam logic [3:0] D2     = 4'((3 * (g + 1)) % 11);
    localparam logic [3:0] S2_RST = 4'((2 * (g + 1) * 3 + 2) % 11);

    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] byte_ext;
    logic [3:0]       sh1;
    logic [3:0]       sh2;
    logic [3:0]       sh1_next;
    logic [3:0]       sh2_next;
    logic [4:0]       sh1_sum;
    logic [4:0]       sh2_sum;
    logic [4:0]       sh2_amt;

    always_comb begin
      byte_ext = {{(ACC_W-8){1'b0}}, name_byte};
      sh2_amt  = {1'b0, sh2} + 5'd13;
      acc_next = byte_valid ? acc + (byte_ext << sh1) + (byte_ext << sh2_amt) : acc;
      sh1_sum  = {1'b0, sh1} + {1'b0, D1};
      sh2_sum  = {1'b0, sh2} + {1'b0, D2};
      sh1_next = (sh1_sum >= 5'd13) ? 4'(sh1_sum - 5'd13) : sh1_sum[3:0];
      sh2_next = (sh2_sum >= 5'd11) ? 4'(sh2_sum - 5'd11) : sh2_sum[3:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        acc <= '0;
        sh1 <= S1_RST;
        sh2 <= S2_RST;
      end else if (accept) begin
        if (end_of_name) begin
          acc <= '0;
          sh1 <= S1_RST;
          sh2 <= S2_RST;
        end else if (byte_valid) begin
          acc <= acc_next;
          sh1 <= sh1_next;
          sh2 <= sh2_next;
        end
      end
    end

    assign snapshot[g*ACC_W +: ACC_W] = acc_next;
  end

endmodule

// ===== rtl/core/chash_queue.sv =====
// ---------------------------------------------------------------------------
// chash_queue
// Two-entry queue of finished accumulator sets between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chash_queue
  import chash_pkg::*;
#(
  parameter int WIDTH = HASH_BYTES_DEF * ACC_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output q_status_t        status
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/chash_back.sv =====
// ---------------------------------------------------------------------------
// chash_back
// Finalizes the queued accumulators one lane at a time and emits hash bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chash_back
  import chash_pkg::*;
#(
  parameter int HASH_BYTES = HASH_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [HASH_BYTES*ACC_W-1:0] head,
  input  q_status_t                   q_status,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,
  output logic [2:0]                  m_tuser,
  output logic                        m_tlast,
  output fin_status_t                 status
);

  localparam int LANE_W = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;

  fin_state_t          state;
  fin_state_t          state_next;
  logic [LANE_W-1:0]   lane;
  logic [LANE_W-1:0]   lane_inc;
  logic [STEP_W-1:0]   step;
  logic [ACC_W-1:0]    cur;
  logic [REM_A_W-1:0]  rem_a;
  logic [REM_B_W-1:0]  rem_b;
  logic [REM_C_W-1:0]  rem_c;
  logic [7:0]          hash_sum;
  logic                lane_last;
  logic                step_last;
  logic                start;
  logic                calc;
  logic                fire;

  assign lane_inc  = lane + LANE_W'(1);
  assign lane_last = (lane == LANE_W'(HASH_BYTES - 1));
  assign step_last = (step == STEP_W'(NIB_STEPS - 1));
  assign hash_sum  = rem_a[7:0] + rem_b[7:0] + rem_c;

  always_comb begin
    state_next = state;
    case (state)
      FIN_IDLE: begin
        if (!q_status.empty) begin
          state_next = FIN_CALC;
        end
      end
      FIN_CALC: begin
        if (step_last) begin
          state_next = FIN_EMIT;
        end
      end
      FIN_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = lane_last ? FIN_IDLE : FIN_CALC;
        end
      end
      default: state_next = FIN_IDLE;
    endcase
  end

  always_comb begin
    start = 1'b0;
    calc  = 1'b0;
    fire  = 1'b0;
    case (state)
      FIN_IDLE: start = ~q_status.empty;
      FIN_CALC: calc  = 1'b1;
      FIN_EMIT: fire  = ~m_tvalid | m_tready;
      default: begin
        start = 1'b0;
      end
    endcase
  end

  assign pop         = fire & lane_last;
  assign status.busy = (state != FIN_IDLE);
  assign status.emit = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FIN_IDLE;
      lane  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        lane <= '0;
        step <= '0;
      end else if (calc) begin
        step <= step + STEP_W'(1);
      end else if (fire && !lane_last) begin
        lane <= lane_inc;
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur   <= head[0 +: ACC_W];
      rem_a <= '0;
      rem_b <= '0;
      rem_c <= '0;
    end else if (calc) begin
      rem_a <= REM_A_W'(rem_nibble(REM_W'(rem_a), cur[ACC_W-1 -: NIB_W], REM_W'(MOD_A)));
      rem_b <= REM_B_W'(rem_nibble(REM_W'(rem_b), cur[ACC_W-1 -: NIB_W], REM_W'(MOD_B)));
      rem_c <= REM_C_W'(rem_nibble(REM_W'(rem_c), cur[ACC_W-1 -: NIB_W], REM_W'(MOD_C)));
      cur   <= cur << NIB_W;
    end else if (fire && !lane_last) begin
      cur   <= head[lane_inc*ACC_W +: ACC_W];
      rem_a <= '0;
      rem_b <= '0;
      rem_c <= '0;
    end
  end

  // Output register: the next lane computes while this byte waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= hash_sum;
      m_tuser <= 3'(lane);
      m_tlast <= lane_last;
    end
  end

endmodule

// ===== bench/tb_class_name_id_hash.sv =====
// ---------------------------------------------------------------------------
// tb_class_name_id_hash
// Self-checking bench for the streaming name hash. Names are streamed in as
// words on the slave side; a scoreboard keeps its own copy of the eight lane
// accumulators and the two position residues, and predicts the hash words
// that each end-of-name word produces. Master-side words are compared field
// by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_class_name_id_hash
  import chash_pkg::*;
();

  localparam int HASH_BYTES     = HASH_BYTES_DEF;
  localparam int RESET_CYCLES   = 11;
  // Sized from the back-end work per hash byte, with a margin for the queue.
  localparam int DRAIN_CYCLES   = 9 * HASH_BYTES + 20;
  localparam int RX_HOLD_CYCLES = 400;
  // Cycles with no word moving on either side before the run is abandoned.
  localparam int QUIET_LIMIT    = 4000;
  localparam int RANDOM_ITEMS   = 445;
  localparam int MAX_REPORTS    = 50;

  // One expected word on the master side.
  typedef struct {
    logic [7:0] hash_byte;
    logic [2:0] byte_index;
    logic       last_byte;
  } hash_word_t;

  // Scoreboard: mirrors the hash state and holds the hash words still owed.
  class name_hash_scoreboard;
    logic [31:0]  lane_acc[HASH_BYTES];
    int unsigned  pos_mod13;
    int unsigned  pos_mod11;
    hash_word_t   owed_words[$];
    int           mismatch_count;
    int           names_done;

    function new();
      mismatch_count = 0;
      names_done     = 0;
      clear_name();
    endfunction

    function void clear_name();
      foreach (lane_acc[i]) lane_acc[i] = '0;
      pos_mod13 = 2;
      pos_mod11 = 2;
    endfunction

    // Every lane takes the character twice, at two position-dependent shifts.
    function void absorb_char(logic [7:0] ch);
      int unsigned sh_lo;
      int unsigned sh_hi;
      for (int i = 0; i < HASH_BYTES; i++) begin
        sh_lo = (pos_mod13 * (i + 1) * 5 + 4) % 13;
        sh_hi = (pos_mod11 * (i + 1) * 3 + 2) % 11 + 13;
        lane_acc[i] += (32'(ch) << sh_lo) + (32'(ch) << sh_hi);
      end
      pos_mod13 = (pos_mod13 >= 12) ? 0 : pos_mod13 + 1;
      pos_mod11 = (pos_mod11 >= 10) ? 0 : pos_mod11 + 1;
    endfunction

    // Fold each lane to a byte through the three remainders, then start over.
    function void finalize_name();
      hash_word_t  w;
      logic [31:0] t;
      logic [31:0] folded;
      for (int k = 0; k < HASH_BYTES; k++) begin
        t            = lane_acc[k];
        folded       = t % MOD_A + t % MOD_B + t % MOD_C;
        w.hash_byte  = folded[7:0];
        w.byte_index = 3'(k);
        w.last_byte  = (k == HASH_BYTES - 1);
        owed_words.push_back(w);
      end
      names_done++;
      clear_name();
    endfunction

    // Called for every word accepted on the slave side.
    function void note_word(logic [7:0] ch, logic valid, logic last);
      if (valid) absorb_char(ch);
      if (last) finalize_name();
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    // Called for every word accepted on the master side.
    task check_result(logic [7:0] hash_byte, logic [2:0] byte_index, logic last_byte);
      hash_word_t w;
      if (owed_words.size() == 0) begin
        report_mismatch($sformatf("unexpected hash word %02h index %0d last %0b",
                                  hash_byte, byte_index, last_byte));
        return;
      end
      w = owed_words.pop_front();
      if (hash_byte !== w.hash_byte)
        report_mismatch($sformatf("hash byte %02h, expected %02h (index %0d)",
                                  hash_byte, w.hash_byte, w.byte_index));
      if (byte_index !== w.byte_index)
        report_mismatch($sformatf("byte index %0d, expected %0d", byte_index, w.byte_index));
      if (last_byte !== w.last_byte)
        report_mismatch($sformatf("last flag %0b, expected %0b (index %0d)",
                                  last_byte, w.last_byte, w.byte_index));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] name_byte
  logic       s_tuser;   // [0] byte_valid
  logic       s_tlast;   // end_of_name
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] hash_byte
  logic [2:0] m_tuser;   // [2:0] byte_index
  logic       m_tlast;   // last_byte

  name_hash_scoreboard sb = new();

  // Idle rates in percent, changed by the stimulus between phases.
  int tx_idle_pct = 25;
  int rx_idle_pct = 87;
  // Set by the stimulus to make the receiver stop for a long stretch.
  bit rx_hold_pending = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;

  class_name_id_hash #(
    .HASH_BYTES(HASH_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Handshakes are sampled right at the rising edge, before any of this
  // step's nonblocking updates land, so both sides see the pre-edge values.
  // The same block runs the watchdog on cycles where no word moves.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random ready at the current idle rate. On request it drops
  // ready for a long stretch so that the queue fills and s_tready falls.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one word, with random gaps ahead of it, and return at the edge
  // where it is taken. Only one nonblocking write per signal per step.
  task automatic send_word(input logic [7:0] ch, input logic valid, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= valid;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (valid || last) items_sent++;
  endtask

  // A word that the block ignores, with junk in the data field.
  task automatic send_idle_word();
    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  // A well-formed name of random characters. The end marker either carries
  // the final character or stands alone; stray idle words may fall inside.
  task automatic send_random_name(input int len, input bit end_carries_char);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) send_idle_word();
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    if (end_carries_char) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    else send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Mostly short names so the back end, not the front, sets the pace;
  // now and then a long one walks the position residues around many times.
  function automatic int pick_name_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 6);
    if (r < 90) return $urandom_range(7, 25);
    return $urandom_range(26, 60);
  endfunction

  task automatic run_random_items(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        send_random_name(pick_name_length(), 1'($urandom_range(0, 1)));
      end else begin
        // Noise: every field random, so idle words, lone characters and
        // bare end markers turn up at arbitrary points.
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    s_tlast  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part. An empty name right out of reset must hash to zeros.
    send_word(8'h5A, 1'b0, 1'b1);
    // Extreme characters, a zero character that only advances the position,
    // an ignored word with junk data in the middle, and an end marker that
    // carries the last character.
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hAA, 1'b0, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h7F, 1'b1, 1'b1);
    // Fourteen all-ones characters wrap both position residues and push the
    // lanes well up, then a bare end marker closes the name.
    for (int i = 0; i < 14; i++) send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // Back-to-back empty name, then a one-character name ended in one word.
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);

    // Random part in three idling phases: slow receiver, slow sender, none.
    run_random_items(RANDOM_ITEMS / 3);
    tx_idle_pct = 87;
    rx_idle_pct = 25;
    run_random_items(RANDOM_ITEMS / 3);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // The receiver stops while the sender keeps streaming at full rate.
    rx_hold_pending = 1'b1;
    run_random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    s_tvalid <= 1'b0;
    // One more edge so the monitor has noted the last word before draining.
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
